// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define MP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property checked during reset as well.
`define MP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- sv/mp2_pkg.sv -----
`default_nettype none
package mp2_pkg;

  localparam int CFG_BITS = 11;
  localparam int MIN_SIZE = 2;
  localparam int MASK_BITS = 2;

  typedef enum logic [MASK_BITS-1:0] {
    CODE_ZERO    = 2'd0,
    CODE_QUARTER = 2'd1,
    CODE_ONE     = 2'd2
  } mask_code_e;

  typedef enum logic {
    REG_PLANE_WIDTH  = 1'b0,
    REG_PLANE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    mask_code_e br;
    mask_code_e bl;
    mask_code_e tr;
    mask_code_e tl;
  } mask_set_t;

  // Per-transaction controls from the counters to the line store and output.
  typedef struct packed {
    logic hold_en;
    logic wr_en;
    logic rd_en;
    logic emit;
    logic eop;
  } step_t;

  // Column counter width; at least two bits so the pair address is never empty.
  function automatic int col_bits(input int max_w);
    return (max_w > 2) ? $clog2(max_w) : 2;
  endfunction

endpackage
`default_nettype wire

// ----- sv/mp2_ctrl.sv -----
`default_nettype none
module mp2_ctrl import mp2_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = col_bits(MAX_WIDTH),
  localparam int AW = CW - 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire cfg_reg_e            cfg_addr_i,
  input  wire logic [CFG_BITS-1:0] cfg_data_i,
  input  wire logic                accept_i,
  output step_t                    step_o,
  output logic [AW-1:0]            addr_o
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int LWW = (WW > CFG_BITS) ? WW : CFG_BITS;
  localparam int LHW = (HW > CFG_BITS) ? HW : CFG_BITS;

  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [LWW-1:0] cfg_w_ext;
  logic [LHW-1:0] cfg_h_ext;
  logic [WW-1:0]  width_clamp;
  logic [HW-1:0]  height_clamp;
  logic [CW:0]    col_nx;
  logic [RW:0]    row_nx;
  logic           col_wrap, row_wrap, last_win;

  // Out-of-range sizes are clamped once, at write time.
  assign cfg_w_ext = LWW'(cfg_data_i);
  assign cfg_h_ext = LHW'(cfg_data_i);

  always_comb begin
    if (cfg_w_ext < LWW'(MIN_SIZE)) begin
      width_clamp = WW'(MIN_SIZE);
    end else if (cfg_w_ext > LWW'(MAX_WIDTH)) begin
      width_clamp = WW'(MAX_WIDTH);
    end else begin
      width_clamp = WW'(cfg_w_ext);
    end
    if (cfg_h_ext < LHW'(MIN_SIZE)) begin
      height_clamp = HW'(MIN_SIZE);
    end else if (cfg_h_ext > LHW'(MAX_HEIGHT)) begin
      height_clamp = HW'(MAX_HEIGHT);
    end else begin
      height_clamp = HW'(cfg_h_ext);
    end
  end

  assign col_nx   = {1'b0, col_q} + (CW+1)'(1);
  assign row_nx   = {1'b0, row_q} + (RW+1)'(1);
  assign col_wrap = col_nx >= (CW+1)'(width_q);
  assign row_wrap = row_nx >= (RW+1)'(height_q);
  assign last_win = (col_nx == (CW+1)'({width_q[WW-1:1], 1'b0})) &&
                    (row_nx == (RW+1)'({height_q[HW-1:1], 1'b0}));

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PLANE_WIDTH:  width_d  = width_clamp;
        REG_PLANE_HEIGHT: height_d = height_clamp;
        default:          width_d  = width_q;
      endcase
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : RW'(row_nx);
      end else begin
        col_d = CW'(col_nx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(MIN_SIZE);
      height_q <= HW'(MIN_SIZE);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // Even rows fill the line store in pairs; odd rows read a pair at the even
  // column and close the window at the odd column.
  assign step_o.hold_en = accept_i & ~col_q[0];
  assign step_o.wr_en   = accept_i & ~row_q[0] & col_q[0];
  assign step_o.rd_en   = accept_i & row_q[0] & ~col_q[0];
  assign step_o.emit    = accept_i & row_q[0] & col_q[0];
  assign step_o.eop     = last_win;
  assign addr_o         = col_q[CW-1:1];

endmodule
`default_nettype wire

// ----- sv/mp2_line.sv -----
`default_nettype none
module mp2_line import mp2_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int VALUE_BITS = 16,
  localparam int AW = col_bits(MAX_WIDTH) - 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire step_t                        step_i,
  input  wire logic [AW-1:0]                addr_i,
  input  wire logic signed [VALUE_BITS-1:0] pixel_i,
  output logic signed [VALUE_BITS-1:0]      top_left_o,
  output logic signed [VALUE_BITS-1:0]      top_right_o,
  output logic signed [VALUE_BITS-1:0]      left_o
);

  localparam int DEPTH = (MAX_WIDTH > 2) ? (MAX_WIDTH + 1) / 2 : 2;

  logic [2*VALUE_BITS-1:0]        pair_mem [DEPTH];
  logic [2*VALUE_BITS-1:0]        rd_q;
  logic signed [VALUE_BITS-1:0]   hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (step_i.hold_en) begin
      hold_q <= pixel_i;
    end
  end

  // Upper pixel pair {right, left} at address column/2.
  always_ff @(posedge clk_i) begin
    if (step_i.wr_en) begin
      pair_mem[addr_i] <= {pixel_i, hold_q};
    end
    if (step_i.rd_en) begin
      rd_q <= pair_mem[addr_i];
    end
  end

  assign top_left_o  = rd_q[VALUE_BITS-1:0];
  assign top_right_o = rd_q[2*VALUE_BITS-1:VALUE_BITS];
  assign left_o      = hold_q;

endmodule
`default_nettype wire

// ----- sv/mp2_win.sv -----
`default_nettype none
module mp2_win import mp2_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic signed [VALUE_BITS-1:0] tl_i,
  input  wire logic signed [VALUE_BITS-1:0] tr_i,
  input  wire logic signed [VALUE_BITS-1:0] bl_i,
  input  wire logic signed [VALUE_BITS-1:0] br_i,
  output logic signed [VALUE_BITS-1:0]      max_o,
  output mask_set_t                         mask_o
);

  logic [1:0]                   best;
  logic signed [VALUE_BITS-1:0] best_v;
  logic                         all_eq;

  // Strict compares keep the first maximum in scan order.
  always_comb begin
    best   = 2'd0;
    best_v = tl_i;
    if (tr_i > best_v) begin
      best   = 2'd1;
      best_v = tr_i;
    end
    if (bl_i > best_v) begin
      best   = 2'd2;
      best_v = bl_i;
    end
    if (br_i > best_v) begin
      best   = 2'd3;
      best_v = br_i;
    end
  end

  assign all_eq = (tl_i == tr_i) && (tl_i == bl_i) && (tl_i == br_i);
  assign max_o  = best_v;

  always_comb begin
    if (all_eq) begin
      mask_o = '{br: CODE_QUARTER, bl: CODE_QUARTER, tr: CODE_QUARTER, tl: CODE_QUARTER};
    end else begin
      mask_o.tl = (best == 2'd0) ? CODE_ONE : CODE_ZERO;
      mask_o.tr = (best == 2'd1) ? CODE_ONE : CODE_ZERO;
      mask_o.bl = (best == 2'd2) ? CODE_ONE : CODE_ZERO;
      mask_o.br = (best == 2'd3) ? CODE_ONE : CODE_ZERO;
    end
  end

endmodule
`default_nettype wire

// ----- sv/mp2_outq.sv -----
`default_nettype none
module mp2_outq #(
  parameter int WIDTH = 25
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign valid_o = cnt_q != 2'd0;
  assign ready_o = cnt_q != 2'd2;
  assign pop     = valid_o & pop_ready_i;
  assign data_o  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/max_pool_2x2_with_grad_mask.sv -----
// 2x2 stride-2 max pooling with backward mask codes.
// Input stream s_axis: one signed Q8.8 pixel per transaction, raster order,
// planes back to back. Output stream m_axis: one transaction per complete
// window, carrying the window maximum and a 2-bit code per position
// (0 zero, 1 quarter, 2 one); tlast marks the last window of the plane.
// Config channel cfg_*: index 0 plane width, 1 plane height, always ready;
// a write restarts the plane at its top-left pixel. Write only while idle.
// Throughput: one pixel per cycle while s_axis_tready is high. A window's
// result is registered into the output queue as the bottom-right pixel of
// its window is taken. The upper row lives in a one-port pair store (two
// pixels per word), read at the even column of the odd row so the pair is
// ready when the window closes. A two-entry output queue decouples the
// sides: s_axis_tready drops only when both entries hold results the receiver has not taken.
// Reset: width and height return to 2, counters to the top-left pixel, the
// queue empties. The line store needs no clearing.
`default_nettype none
module max_pool_2x2_with_grad_mask import mp2_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int VALUE_BITS = 16,
  localparam int IN_W  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_BITS + 4 * MASK_BITS + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [IN_W-1:0]     s_axis_tdata,   // pixel_value
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // pooled_value, mask_top_left, mask_top_right, mask_bottom_left,
  // mask_bottom_right, zero fill
  output logic [OUT_W-1:0]         m_axis_tdata,
  output logic                     m_axis_tlast,   // end_of_plane
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_addr_i,
  input  wire logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int AW    = col_bits(MAX_WIDTH) - 1;
  localparam int RES_W = VALUE_BITS + 4 * MASK_BITS + 1;

  step_t                        step;
  logic [AW-1:0]                addr;
  logic                         accept;
  logic signed [VALUE_BITS-1:0] pixel;
  logic signed [VALUE_BITS-1:0] top_left, top_right, left_px, win_max;
  mask_set_t                    mask;
  logic [RES_W-1:0]             res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid & s_axis_tready;
  assign pixel       = s_axis_tdata[VALUE_BITS-1:0];

  mp2_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_addr_i (cfg_reg_e'(cfg_addr_i)),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .step_o     (step),
    .addr_o     (addr)
  );

  mp2_line #(
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .addr_i      (addr),
    .pixel_i     (pixel),
    .top_left_o  (top_left),
    .top_right_o (top_right),
    .left_o      (left_px)
  );

  mp2_win #(
    .VALUE_BITS (VALUE_BITS)
  ) u_win (
    .tl_i   (top_left),
    .tr_i   (top_right),
    .bl_i   (left_px),
    .br_i   (pixel),
    .max_o  (win_max),
    .mask_o (mask)
  );

  assign res_in = {step.eop, mask, win_max};

  mp2_outq #(
    .WIDTH (RES_W)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step.emit),
    .data_i      (res_in),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (res_out)
  );

  assign m_axis_tdata = OUT_W'(res_out[RES_W-2:0]);
  assign m_axis_tlast = res_out[RES_W-1];

endmodule
`default_nettype wire

// ----- sv/mp2_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module mp2_checker import mp2_pkg::*; #(
  parameter int VALUE_BITS = 16,
  localparam int IN_W  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_BITS + 4 * MASK_BITS + 7) / 8) * 8
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [IN_W-1:0]     s_axis_tdata,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OUT_W-1:0]    m_axis_tdata,
  input wire logic                m_axis_tlast,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o,
  input wire logic                cfg_addr_i,
  input wire logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int V = VALUE_BITS;

  logic [MASK_BITS-1:0] tl, tr, bl, br;
  assign tl = m_axis_tdata[V+1:V];
  assign tr = m_axis_tdata[V+3:V+2];
  assign bl = m_axis_tdata[V+5:V+4];
  assign br = m_axis_tdata[V+7:V+6];

  `MP_ASSERT(a_out_hold_valid, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid), "result dropped while stalled")
  `MP_ASSERT(a_out_hold_data, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled result changed")
  `MP_ASSERT(a_full_has_out, clk_i, rst_ni, (!s_axis_tready |-> m_axis_tvalid), "input stalled with no result pending")
  `MP_ASSERT(a_quarter_all, clk_i, rst_ni, (m_axis_tvalid && tl == CODE_QUARTER |-> tr == CODE_QUARTER && bl == CODE_QUARTER && br == CODE_QUARTER), "partial quarter mask")
  `MP_ASSERT(a_one_winner, clk_i, rst_ni, (m_axis_tvalid && tl != CODE_QUARTER |-> $onehot({tl == CODE_ONE, tr == CODE_ONE, bl == CODE_ONE, br == CODE_ONE}) && tr != CODE_QUARTER && bl != CODE_QUARTER && br != CODE_QUARTER), "mask must have exactly one winner")

endmodule

bind max_pool_2x2_with_grad_mask mp2_checker #(.VALUE_BITS(VALUE_BITS)) u_mp2_checker (.*);
`default_nettype wire
